>>> design/pbi_pkg.sv
package pbi_pkg;

	localparam int unsigned DEFAULT_ENTRIES = 256;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned RGB_W = 3 * CHAN_W;
	localparam int unsigned IDX_W = 8;
	localparam int unsigned COLOR555_W = 15;
	localparam int unsigned CHAN555_W = 5;
	localparam int unsigned CHAN_SHIFT = 3;

	typedef struct packed {
		logic              start_image;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [IDX_W-1:0]      color_index;
		logic                  is_new;
		logic [COLOR555_W-1:0] palette_color;
		logic                  overflow;
	} result_t;

	// One slot of the cell chain: a pixel on its way along the palette.
	typedef struct packed {
		logic             vld;
		logic             start_image;
		logic [RGB_W-1:0] rgb;
		logic             hit;
		logic             is_new;
		logic [IDX_W-1:0] idx;
	} cell_bus_t;

	function automatic logic [COLOR555_W-1:0] to_rgb555(input logic [RGB_W-1:0] rgb);
		logic [CHAN555_W-1:0] r5;
		logic [CHAN555_W-1:0] g5;
		logic [CHAN555_W-1:0] b5;
		r5 = rgb[CHAN_W-1:CHAN_SHIFT];
		g5 = rgb[2*CHAN_W-1:CHAN_W+CHAN_SHIFT];
		b5 = rgb[3*CHAN_W-1:2*CHAN_W+CHAN_SHIFT];
		return {b5, g5, r5};
	endfunction

endpackage

>>> design/pbi_cell.sv
module pbi_cell #(
	parameter int unsigned CELL_INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pbi_pkg::cell_bus_t bus_in,
	output pbi_pkg::cell_bus_t bus_out
);

	logic                      entry_vld_q;
	logic [pbi_pkg::RGB_W-1:0] color_q;
	logic                      entry_live;
	logic                      match;
	logic                      claim;
	logic                      out_vld_q;
	pbi_pkg::cell_bus_t        data_q;
	pbi_pkg::cell_bus_t        next_data;

	// A start marker empties this cell as it passes, before its own lookup.
	assign entry_live = entry_vld_q && !(bus_in.vld && bus_in.start_image);
	assign match = bus_in.vld && !bus_in.hit && entry_live && (color_q == bus_in.rgb);
	assign claim = bus_in.vld && !bus_in.hit && !entry_live;

	always_comb begin
		next_data = bus_in;
		if (match || claim) begin
			next_data.hit = 1'b1;
			next_data.is_new = claim;
			next_data.idx = pbi_pkg::IDX_W'(CELL_INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			entry_vld_q <= entry_live || claim;
			out_vld_q <= bus_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= next_data;
		if (claim) begin
			color_q <= bus_in.rgb;
		end
	end

	always_comb begin
		bus_out = data_q;
		bus_out.vld = out_vld_q;
	end

endmodule

>>> design/palette_builder_indexer.sv
// Palette builder and indexer for a stream of 24-bit RGB pixels.
//
// Input channel: an item (one pixel) is taken at a rising clock edge where
// start is high and busy is low. The block never raises busy, so one pixel
// may be given on every cycle. Setting start_image in an item empties the
// palette and clears the overflow flag before that pixel is looked up.
//
// Result channel: each item gives one result on the result port, marked by
// done for exactly one cycle. The receiver cannot stall the block and must
// take every result in the cycle in which it is shown.
//
// The palette is a row of PALETTE_ENTRIES cells, each holding one color.
// A pixel moves one cell per cycle, matching a stored color or claiming the
// first empty cell; after the last cell its result is registered and shown
// on the result port. Pixels follow one another through the row, one per
// cycle, and results leave in the order the items came in.
//
// Reset empties every cell, drops all items in flight and clears overflow.
module palette_builder_indexer #(
	parameter int unsigned PALETTE_ENTRIES = pbi_pkg::DEFAULT_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pbi_pkg::pixel_t  pixel,
	output logic             done,
	output pbi_pkg::result_t result
);

	localparam int unsigned LATENCY = PALETTE_ENTRIES + 1;

	pbi_pkg::cell_bus_t chain [PALETTE_ENTRIES+1];
	pbi_pkg::cell_bus_t tail;
	pbi_pkg::result_t   next_result;
	logic               next_overflow;
	logic               overflow_q;
	logic               done_q;
	pbi_pkg::result_t   result_q;

	assign busy = 1'b0;

	always_comb begin
		chain[0].vld = start && !busy;
		chain[0].start_image = pixel.start_image;
		chain[0].rgb = {pixel.blue, pixel.green, pixel.red};
		chain[0].hit = 1'b0;
		chain[0].is_new = 1'b0;
		chain[0].idx = '0;
	end

	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		pbi_cell #(
			.CELL_INDEX(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.bus_in(chain[k]),
			.bus_out(chain[k+1])
		);
	end

	assign tail = chain[PALETTE_ENTRIES];

	// A pixel that leaves the row unresolved found the palette full.
	assign next_overflow = (overflow_q && !tail.start_image) || !tail.hit;

	always_comb begin
		next_result.color_index = tail.hit ? tail.idx : '0;
		next_result.is_new = tail.hit && tail.is_new;
		next_result.palette_color = tail.hit ? pbi_pkg::to_rgb555(tail.rgb) : '0;
		next_result.overflow = next_overflow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= tail.vld;
			if (tail.vld) begin
				overflow_q <= next_overflow;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.vld) begin
			result_q <= next_result;
		end
	end

	assign done = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item did not produce a result after the cell row latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!tail.vld |=> !done)
		else $error("result strobe without an item leaving the cell row");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && !tail.hit) |=> (done && result.overflow && !result.is_new
			&& result.color_index == '0 && result.palette_color == '0))
		else $error("palette full item gave a wrong result");

	a_new_no_ovf_change: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_new && !$past(tail.start_image))
			|-> (result.overflow == $past(overflow_q)))
		else $error("adding an entry changed the overflow flag");

endmodule
